@@ design/pca_pkg.sv @@
// Shared constants for the Pearson correlation accumulator.
// No dependencies; every other design file but pca_alu imports this package.
`default_nettype none

package pca_pkg;

  // Default configuration of the block
  localparam int COUNT_BITS_DEF  = 20;
  localparam int RATING_BITS_DEF = 3;

  // Fixed widths of the coefficient path
  localparam int CORR_BITS  = 16;
  localparam int QUOT_BITS  = 33;  // floor(2^32 * cov^2 / (vx * vy)) never exceeds 2^32
  localparam int ROOT_BITS  = 17;  // integer square root of the quotient
  localparam int STEP_BITS  = 6;   // iteration counter for divide and root loops

  localparam logic [CORR_BITS-1:0] CORR_MAX = 16'h7fff;
  localparam logic [ROOT_BITS-1:0] ROOT_CAP = 17'h0ffff;

endpackage

`default_nettype wire

@@ design/pca_if.sv @@
// Stream interfaces for rating pairs and correlation results.
// Depends on pca_pkg for default widths.
`default_nettype none

interface pca_pair_if
  import pca_pkg::*;
#(
  parameter int RATING_BITS = RATING_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [RATING_BITS-1:0] first_rating;
  logic [RATING_BITS-1:0] second_rating;
  logic                   pair_present;
  logic                   last;

  modport source (output valid, first_rating, second_rating, pair_present, last,
                  input ready);
  modport sink   (input valid, first_rating, second_rating, pair_present, last,
                  output ready);
endinterface

interface pca_result_if
  import pca_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CORR_BITS-1:0] correlation;
  logic [COUNT_BITS-1:0]       pair_count;
  logic                        undefined;
  logic                        overflow;

  modport source (output valid, correlation, pair_count, undefined, overflow,
                  input ready);
  modport sink   (input valid, correlation, pair_count, undefined, overflow,
                  output ready);
endinterface

`default_nettype wire

@@ design/pca_accum.sv @@
// Running sums of one set of rating pairs, one pair per cycle while take is high.
// Depends on pca_pkg.
`default_nettype none

module pca_accum
  import pca_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int RATING_BITS = RATING_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              take,
  input  wire logic [RATING_BITS-1:0]            x,
  input  wire logic [RATING_BITS-1:0]            y,
  input  wire logic                              present,
  input  wire logic                              clear,
  output logic [COUNT_BITS-1:0]                  count,
  output logic [COUNT_BITS+RATING_BITS-1:0]      sum_first,
  output logic [COUNT_BITS+RATING_BITS-1:0]      sum_second,
  output logic [COUNT_BITS+2*RATING_BITS-1:0]    sum_first_squared,
  output logic [COUNT_BITS+2*RATING_BITS-1:0]    sum_second_squared,
  output logic [COUNT_BITS+2*RATING_BITS-1:0]    sum_products,
  output logic                                   dropped
);

  localparam int SW = COUNT_BITS + RATING_BITS;
  localparam int QW = COUNT_BITS + 2 * RATING_BITS;

  logic [2*RATING_BITS-1:0] xx, yy, xy;
  logic                     full;

  // Small products of the incoming word
  assign xx   = x * x;
  assign yy   = y * y;
  assign xy   = x * y;
  assign full = (count == {COUNT_BITS{1'b1}});

  // Accumulate a present pair, flag it once the count is saturated
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count              <= '0;
      sum_first          <= '0;
      sum_second         <= '0;
      sum_first_squared  <= '0;
      sum_second_squared <= '0;
      sum_products       <= '0;
      dropped            <= 1'b0;
    end else if (take && present) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count              <= count + 1'b1;
        sum_first          <= sum_first + SW'(x);
        sum_second         <= sum_second + SW'(y);
        sum_first_squared  <= sum_first_squared + QW'(xx);
        sum_second_squared <= sum_second_squared + QW'(yy);
        sum_products       <= sum_products + QW'(xy);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/pca_alu.sv @@
// Shared add/subtract unit of the coefficient sequencer.
// Depends on nothing beyond its width parameter.
`default_nettype none

module pca_alu #(
  parameter int W = 8
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         sub,
  output logic [W-1:0]      result,
  output logic              borrow
);

  logic [W:0] total;

  // Subtract as add of the complement, borrow when no carry comes out
  assign total  = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
  assign result = total[W-1:0];
  assign borrow = sub & ~total[W];

endmodule

`default_nettype wire

@@ design/pca_seq.sv @@
// Sequencer that turns the running sums into a rounded Q1.15 coefficient.
// Shift-add multiplies, restoring divide and square root all share pca_alu.
// Depends on pca_pkg and pca_alu.
`default_nettype none

module pca_seq
  import pca_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int RATING_BITS = RATING_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               take,
  input  wire logic                               last,
  output logic                                    in_ready,
  input  wire logic [COUNT_BITS-1:0]              count,
  input  wire logic [COUNT_BITS+RATING_BITS-1:0]  sum_first,
  input  wire logic [COUNT_BITS+RATING_BITS-1:0]  sum_second,
  input  wire logic [COUNT_BITS+2*RATING_BITS-1:0] sum_first_squared,
  input  wire logic [COUNT_BITS+2*RATING_BITS-1:0] sum_second_squared,
  input  wire logic [COUNT_BITS+2*RATING_BITS-1:0] sum_products,
  input  wire logic                               dropped,
  output logic                                    clear,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [CORR_BITS-1:0]             out_corr,
  output logic [COUNT_BITS-1:0]                   out_count,
  output logic                                    out_undef,
  output logic                                    out_ovf
);

  localparam int VW = 2 * COUNT_BITS + 2 * RATING_BITS;  // variance and covariance terms
  localparam int PW = 2 * VW;                            // their products
  localparam int AW = PW + 2;                            // shared unit width

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_VX1  = 4'd3;
  localparam logic [3:0] S_VX2  = 4'd4;
  localparam logic [3:0] S_VY1  = 4'd5;
  localparam logic [3:0] S_VY2  = 4'd6;
  localparam logic [3:0] S_CV1  = 4'd7;
  localparam logic [3:0] S_CV2  = 4'd8;
  localparam logic [3:0] S_CV3  = 4'd9;
  localparam logic [3:0] S_CHK  = 4'd10;
  localparam logic [3:0] S_PR1  = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_SQ   = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  logic [3:0]             state, ret;
  logic [AW-1:0]          acc, ma, mb;
  logic [VW-1:0]          v1, vx, vy, mag;
  logic [PW-1:0]          pp;
  logic                   neg;
  logic [QUOT_BITS-1:0]   quot;
  logic [QUOT_BITS:0]     qsh;
  logic [ROOT_BITS-1:0]   root;
  logic [STEP_BITS-1:0]   step;
  logic signed [CORR_BITS-1:0] res_corr;
  logic                   res_undef;

  logic [AW-1:0]          alu_a, alu_b, alu_y;
  logic                   alu_sub, alu_borrow;
  logic                   emit;

  logic [ROOT_BITS-1:0]   root_cap, kval;
  logic [CORR_BITS-1:0]   mag_q15;

  pca_alu #(.W(AW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .result (alu_y),
    .borrow (alu_borrow)
  );

  // Pick operands of the shared unit for the current step
  always_comb begin
    alu_a   = acc;
    alu_b   = ma;
    alu_sub = 1'b0;
    unique case (state) inside
      S_VX2, S_VY2, S_CV2: begin
        alu_a   = AW'(v1);
        alu_b   = acc;
        alu_sub = 1'b1;
      end
      S_CV3: begin
        alu_a   = acc;
        alu_b   = AW'(v1);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = acc;
        alu_b   = AW'(pp);
        alu_sub = 1'b1;
      end
      S_SQ: begin
        alu_a   = {acc[AW-3:0], qsh[QUOT_BITS:QUOT_BITS-1]};
        alu_b   = AW'({root, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc;
        alu_b   = ma;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Round the root to the nearest odd step: k = floor((min(t, 65535) + 1) / 2)
  assign root_cap = (root > ROOT_CAP) ? ROOT_CAP : root;
  assign kval     = (root_cap + 1'b1) >> 1;
  assign mag_q15  = (kval > ROOT_BITS'(CORR_MAX)) ? CORR_MAX : kval[CORR_BITS-1:0];

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_OUT) && (!out_valid || out_ready);
  assign clear    = emit;

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && last) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (count < COUNT_BITS'(2)) begin
            res_corr  <= '0;
            res_undef <= 1'b1;
            state     <= S_OUT;
          end else begin
            acc   <= '0;
            ma    <= AW'(sum_first_squared);
            mb    <= AW'(count);
            ret   <= S_VX1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // Shift-add step; leave once the multiplier runs out of ones
          if (mb == '0) begin
            state <= ret;
          end else begin
            if (mb[0]) begin
              acc <= alu_y;
            end
            ma <= ma << 1;
            mb <= mb >> 1;
          end
        end
        S_VX1: begin
          v1    <= acc[VW-1:0];
          acc   <= '0;
          ma    <= AW'(sum_first);
          mb    <= AW'(sum_first);
          ret   <= S_VX2;
          state <= S_MUL;
        end
        S_VX2: begin
          vx    <= alu_y[VW-1:0];
          acc   <= '0;
          ma    <= AW'(sum_second_squared);
          mb    <= AW'(count);
          ret   <= S_VY1;
          state <= S_MUL;
        end
        S_VY1: begin
          v1    <= acc[VW-1:0];
          acc   <= '0;
          ma    <= AW'(sum_second);
          mb    <= AW'(sum_second);
          ret   <= S_VY2;
          state <= S_MUL;
        end
        S_VY2: begin
          vy    <= alu_y[VW-1:0];
          acc   <= '0;
          ma    <= AW'(sum_products);
          mb    <= AW'(count);
          ret   <= S_CV1;
          state <= S_MUL;
        end
        S_CV1: begin
          v1    <= acc[VW-1:0];
          acc   <= '0;
          ma    <= AW'(sum_first);
          mb    <= AW'(sum_second);
          ret   <= S_CV2;
          state <= S_MUL;
        end
        S_CV2: begin
          neg <= alu_borrow;
          if (alu_borrow) begin
            state <= S_CV3;
          end else begin
            mag   <= alu_y[VW-1:0];
            state <= S_CHK;
          end
        end
        S_CV3: begin
          mag   <= alu_y[VW-1:0];
          state <= S_CHK;
        end
        S_CHK: begin
          if (vx == '0 || vy == '0) begin
            res_corr  <= '0;
            res_undef <= 1'b1;
            state     <= S_OUT;
          end else begin
            acc   <= '0;
            ma    <= AW'(vx);
            mb    <= AW'(vy);
            ret   <= S_PR1;
            state <= S_MUL;
          end
        end
        S_PR1: begin
          pp    <= acc[PW-1:0];
          acc   <= '0;
          ma    <= AW'(mag);
          mb    <= AW'(mag);
          quot  <= '0;
          step  <= STEP_BITS'(QUOT_BITS);
          ret   <= S_DIV;
          state <= S_MUL;
        end
        S_DIV: begin
          // One quotient bit of 2^32 * cov^2 / (vx * vy) per cycle
          quot <= {quot[QUOT_BITS-2:0], ~alu_borrow};
          acc  <= (alu_borrow ? acc : alu_y) << 1;
          step <= step - 1'b1;
          if (step == STEP_BITS'(1)) begin
            qsh   <= {1'b0, quot[QUOT_BITS-2:0], ~alu_borrow};
            acc   <= '0;
            root  <= '0;
            step  <= STEP_BITS'(ROOT_BITS);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          // One root bit per cycle, two quotient bits brought down
          qsh  <= qsh << 2;
          step <= step - 1'b1;
          if (alu_borrow) begin
            acc  <= alu_a;
            root <= {root[ROOT_BITS-2:0], 1'b0};
          end else begin
            acc  <= alu_y;
            root <= {root[ROOT_BITS-2:0], 1'b1};
          end
          if (step == STEP_BITS'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          res_corr  <= neg ? -$signed(kval[CORR_BITS-1:0]) : $signed(mag_q15);
          res_undef <= 1'b0;
          state     <= S_OUT;
        end
        S_OUT: begin
          // Hand the word to the output register once it is free
          if (emit) begin
            out_valid <= 1'b1;
            out_corr  <= res_corr;
            out_count <= count;
            out_undef <= res_undef;
            out_ovf   <= dropped;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/pearson_correlation_accumulator_top.sv @@
// Channel  | Dir | Payload
// pairs    | in  | first_rating, second_rating, pair_present, last
// result   | out | correlation, pair_count, undefined, overflow
//
// A word without last is taken whenever ready is high; ready stays high for the next word.
// A word with last starts the coefficient run in the shared add/subtract unit:
// eight shift-add multiplies, then a restoring divide and a square root, with
// control states between them; under two pairs or with a zero variance, the run
// ends early with the result undefined.
// Ready is low during the run; the result sits in an output register and only
// a later run waits for it to be taken. Reset clears all sums and control.
// Top level of the Pearson correlation accumulator; depends on pca_pkg, pca_if,
// pca_accum, pca_alu and pca_seq.
`default_nettype none

module pearson_correlation_accumulator_top
  import pca_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int RATING_BITS = RATING_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  pca_pair_if.sink   pairs,
  pca_result_if.source result
);

  logic [COUNT_BITS-1:0]               count;
  logic [COUNT_BITS+RATING_BITS-1:0]   sum_first, sum_second;
  logic [COUNT_BITS+2*RATING_BITS-1:0] sum_first_squared, sum_second_squared, sum_products;
  logic                                dropped, clear, take, ready;

  assign take        = pairs.valid && ready;
  assign pairs.ready = ready;

  pca_accum #(.COUNT_BITS(COUNT_BITS), .RATING_BITS(RATING_BITS)) u_accum (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .x                  (pairs.first_rating),
    .y                  (pairs.second_rating),
    .present            (pairs.pair_present),
    .clear              (clear),
    .count              (count),
    .sum_first          (sum_first),
    .sum_second         (sum_second),
    .sum_first_squared  (sum_first_squared),
    .sum_second_squared (sum_second_squared),
    .sum_products       (sum_products),
    .dropped            (dropped)
  );

  pca_seq #(.COUNT_BITS(COUNT_BITS), .RATING_BITS(RATING_BITS)) u_seq (
    .clk                (clk),
    .rst                (rst),
    .take               (take),
    .last               (pairs.last),
    .in_ready           (ready),
    .count              (count),
    .sum_first          (sum_first),
    .sum_second         (sum_second),
    .sum_first_squared  (sum_first_squared),
    .sum_second_squared (sum_second_squared),
    .sum_products       (sum_products),
    .dropped            (dropped),
    .clear              (clear),
    .out_valid          (result.valid),
    .out_ready          (result.ready),
    .out_corr           (result.correlation),
    .out_count          (result.pair_count),
    .out_undef          (result.undefined),
    .out_ovf            (result.overflow)
  );

endmodule

`default_nettype wire

@@ sim/pearson_correlation_accumulator_top_tb.sv @@
// Self-checking bench for the Pearson correlation accumulator top level.
// Depends on pca_pkg, pca_if and the design files under design/.
`timescale 1ns / 100ps

module pearson_correlation_accumulator_top_tb;
  import pca_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int RAT_W = RATING_BITS_DEF;
  localparam logic [CNT_W-1:0] CNT_FULL = '1;

  typedef struct packed {
    logic signed [CORR_BITS-1:0] corr;
    logic [CNT_W-1:0]            cnt;
    logic                        undef;
    logic                        ovf;
  } coeff_t;

  // Stimulus row: pair word plus an optional typed-in expectation
  typedef struct {
    logic [RAT_W-1:0] x;
    logic [RAT_W-1:0] y;
    logic             pres;
    logic             lst;
    logic             fixed;
    coeff_t           want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures = 0;
  int   send_idle = 0;
  int   recv_stall = 0;

  pca_pair_if   #(.RATING_BITS(RAT_W)) pairs ();
  pca_result_if #(.COUNT_BITS(CNT_W))  result ();

  pearson_correlation_accumulator_top #(.COUNT_BITS(CNT_W), .RATING_BITS(RAT_W)) uut (
    .clk(clk), .rst(rst), .pairs(pairs.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  // Running sums of the set being accumulated
  longint unsigned acc_n, acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy;
  bit              acc_lost;
  coeff_t          coeff_q[$];
  coeff_t          typed_q[$];
  logic            typed_use_q[$];

  // Largest k with 2^32*m^2 >= (2k-1)^2*vx*vy, done in wide unsigned vectors
  function automatic logic [31:0] coeff_magnitude(longint unsigned m, longint unsigned vx,
                                                  longint unsigned vy);
    logic [191:0] lhs, prod, rhs;
    logic [31:0]  lo, hi, k, odd;
    lhs = {64'd0, m} * {128'd0, m};
    lhs = lhs << 32;
    prod = {128'd0, vx} * {128'd0, vy};
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      k = (lo + hi + 1) / 2;
      odd = 2 * k - 1;
      rhs = prod * odd * odd;
      if (lhs >= rhs) lo = k;
      else hi = k - 1;
    end
    return lo;
  endfunction

  function automatic void clear_sums();
    acc_n = 0; acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
    acc_lost = 0;
  endfunction

  // Accumulate one accepted word; on last, push the predicted coefficient
  function automatic void absorb_pair(logic [RAT_W-1:0] x, logic [RAT_W-1:0] y,
                                      logic pres, logic lst);
    coeff_t          c;
    longint unsigned vx, vy, p, q, m;
    logic [31:0]     r;
    if (pres) begin
      if (acc_n < CNT_FULL) begin
        acc_n++; acc_sx += x; acc_sy += y;
        acc_sxx += x * x; acc_syy += y * y; acc_sxy += x * y;
      end else begin
        acc_lost = 1;
      end
    end
    if (!lst) return;
    c.corr = 0;
    c.undef = 1;
    if (acc_n >= 2) begin
      vx = acc_n * acc_sxx - acc_sx * acc_sx;
      vy = acc_n * acc_syy - acc_sy * acc_sy;
      if (vx != 0 && vy != 0) begin
        p = acc_n * acc_sxy;
        q = acc_sx * acc_sy;
        m = (p < q) ? q - p : p - q;
        r = coeff_magnitude(m, vx, vy);
        c.undef = 0;
        if (p < q) c.corr = CORR_BITS'(-r[16:0]);
        else c.corr = (r > 32767) ? CORR_MAX : r[15:0];
      end
    end
    c.cnt = acc_n[CNT_W-1:0];
    c.ovf = acc_lost;
    coeff_q.push_back(c);
    clear_sums();
  endfunction

  // Receiver: stall at random, check every accepted result word
  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    coeff_t w, t;
    logic   use_t;
    if (!rst && result.valid && result.ready) begin
      if (coeff_q.size() == 0) begin
        $display("%0t: unexpected result corr=%0d cnt=%0d", $time, result.correlation,
                 result.pair_count);
        failures++;
      end else begin
        w = coeff_q.pop_front();
        t = typed_q.pop_front();
        use_t = typed_use_q.pop_front();
        if (use_t && w != t) begin
          $display("%0t: typed row exp corr=%0d cnt=%0d undef=%0b ovf=%0b", $time,
                   t.corr, t.cnt, t.undef, t.ovf);
          $display("%0t:       predicted corr=%0d cnt=%0d undef=%0b ovf=%0b", $time,
                   w.corr, w.cnt, w.undef, w.ovf);
          failures++;
        end
        if (result.correlation !== w.corr || result.pair_count !== w.cnt ||
            result.undefined !== w.undef || result.overflow !== w.ovf) begin
          $display("%0t: mismatch exp corr=%0d cnt=%0d undef=%0b ovf=%0b", $time,
                   w.corr, w.cnt, w.undef, w.ovf);
          $display("%0t:          act corr=%0d cnt=%0d undef=%0b ovf=%0b", $time,
                   result.correlation, result.pair_count, result.undefined, result.overflow);
          failures++;
        end
      end
    end
  end

  // Drive one word, holding it until accepted; idle gaps before it
  task automatic send_pair(row_t rw);
    while ($urandom_range(99) < send_idle) begin
      pairs.valid <= 1'b0;
      @(negedge clk);
    end
    pairs.valid <= 1'b1;
    pairs.first_rating <= rw.x;
    pairs.second_rating <= rw.y;
    pairs.pair_present <= rw.pres;
    pairs.last <= rw.lst;
    @(posedge clk);
    while (!pairs.ready) @(posedge clk);
    absorb_pair(rw.x, rw.y, rw.pres, rw.lst);
    if (rw.lst) begin
      typed_q.push_back(rw.want);
      typed_use_q.push_back(rw.fixed);
    end
    @(negedge clk);
  endtask

  function automatic row_t mk(int x, int y, bit pres, bit lst);
    row_t r;
    r.x = RAT_W'(x); r.y = RAT_W'(y); r.pres = pres; r.lst = lst; r.fixed = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t mk_want(int x, int y, bit pres, bit lst, int corr, int cnt,
                                   bit undef);
    row_t r;
    r = mk(x, y, pres, lst);
    r.fixed = 1;
    r.want.corr = CORR_BITS'(corr);
    r.want.cnt = CNT_W'(cnt);
    r.want.undef = undef;
    r.want.ovf = 1'b0;
    return r;
  endfunction

  task automatic drain();
    pairs.valid <= 1'b0;
    while (coeff_q.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  row_t directed[$];

  initial begin
    row_t rw;
    int   len, mode, phase, sent, bx, by;
    pairs.valid = 0; pairs.first_rating = 0; pairs.second_rating = 0;
    pairs.pair_present = 0; pairs.last = 0; result.ready = 0;
    clear_sums();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Empty set, single pair, perfect +/-, zero variance, extremes, mixed sets with absent pairs
    directed.push_back(mk_want(0, 0, 0, 1, 0, 0, 1));
    directed.push_back(mk_want(7, 7, 1, 1, 0, 1, 1));
    directed.push_back(mk(0, 0, 1, 0));
    directed.push_back(mk_want(7, 7, 1, 1, 32767, 2, 0));
    directed.push_back(mk(0, 7, 1, 0));
    directed.push_back(mk_want(7, 0, 1, 1, -32768, 2, 0));
    directed.push_back(mk(3, 5, 1, 0));
    directed.push_back(mk_want(3, 2, 1, 1, 0, 2, 1));
    directed.push_back(mk(1, 2, 1, 0));
    directed.push_back(mk(2, 4, 0, 0));
    directed.push_back(mk(5, 1, 1, 0));
    directed.push_back(mk(6, 6, 1, 0));
    directed.push_back(mk(4, 3, 0, 1));
    directed.push_back(mk(2, 5, 1, 0));
    directed.push_back(mk(6, 3, 1, 0));
    directed.push_back(mk(1, 4, 1, 1));
    foreach (directed[i]) send_pair(directed[i]);
    drain();

    // Random sets over phases of sender idling and receiver stalls; pause to drain between phases
    sent = 0;
    for (phase = 0; phase < 4; phase++) begin
      send_idle  = (phase == 1 || phase == 3) ? (phase == 1 ? 83 : 6) : 0;
      recv_stall = (phase == 2 || phase == 3) ? (phase == 2 ? 83 : 6) : 0;
      while (sent < (phase + 1) * 225) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
        mode = $urandom_range(3);
        bx = $urandom_range(7);
        by = $urandom_range(7);
        for (int j = 0; j < len; j++) begin
          rw = mk($urandom_range(7), $urandom_range(7), $urandom_range(15) != 0, j == len - 1);
          if (mode == 1) rw.y = rw.x;
          if (mode == 2) rw.y = RAT_W'(7) - rw.x;
          if (mode == 3) begin
            rw.x = RAT_W'(bx);
            if ($urandom_range(1)) rw.y = RAT_W'(by);
          end
          send_pair(rw);
          sent++;
        end
      end
      drain();
    end

    if (failures == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/pca_pkg.sv
design/pca_if.sv
design/pca_accum.sv
design/pca_alu.sv
design/pca_seq.sv
design/pearson_correlation_accumulator_top.sv
sim/pearson_correlation_accumulator_top_tb.sv
